// ----- rtl/cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cfs_pkg: shared types and constants for cubic_from_struts
// Transaction payloads, side-band record and pipeline latency figures.
// ----------------------------------------------------------------------------
package cfs_pkg;

    typedef struct packed {
        logic [63:0] start_point;
        logic [63:0] first_handle;
        logic [63:0] second_handle;
        logic [63:0] end_point;
        logic [63:0] on_curve_point;
        logic [63:0] strut_one;
        logic [63:0] strut_two;
        logic [16:0] curve_position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_handle_one_x;
        logic signed [31:0] new_handle_one_y;
        logic signed [31:0] new_handle_two_x;
        logic signed [31:0] new_handle_two_y;
        logic               clipped;
    } t_out_item;

    // rounded, saturated quotient from one divider
    typedef struct packed {
        logic signed [31:0] value;
        logic               clip;
    } t_div_res;

    // travels beside the arithmetic for the endpoint pass-through
    typedef struct packed {
        logic        bypass;
        logic [63:0] handle_one;
        logic [63:0] handle_two;
    } t_side;

    localparam int QBITS     = 32;          // quotient bits resolved
    localparam int FRONT_LAT = 4;           // numerator / denominator stages
    localparam int DIV_LAT   = QBITS + 3;   // sign, range, bits, round

endpackage

// ----- rtl/cfs_num.sv -----
// ----------------------------------------------------------------------------
// cfs_num: numerator pipeline for one coordinate
// n1 = 3s.e1.2^2F - B.2^3F + t^3.P3 - 2s^3.P0, n2 likewise with roles swapped.
// ----------------------------------------------------------------------------
module cfs_num #(
    parameter int FB = 16,
    parameter int NW = 3 * FB + 36
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FB-1:0]        i_t,
    input  logic [FB-1:0]        i_s,
    input  logic signed [31:0]   i_p0,
    input  logic signed [31:0]   i_p3,
    input  logic signed [31:0]   i_b,
    input  logic signed [31:0]   i_e1,
    input  logic signed [31:0]   i_e2,
    output logic signed [NW-1:0] o_n1,
    output logic signed [NW-1:0] o_n2
);

    logic [FB+1:0] k_s3;
    logic [FB+1:0] k_t3;

    logic [FB-1:0]          r_t1, r_s1, r_t2, r_s2;
    logic signed [FB+34:0]  r_e1k1, r_e2k1, r_e1k2, r_e2k2, r_e1k3, r_e2k3;
    logic signed [31:0]     r_b1, r_b2, r_b3;
    logic signed [FB+32:0]  r_p3t, r_p0s;
    logic signed [2*FB+32:0] r_p3tt, r_p0ss;
    logic signed [3*FB+32:0] r_t3p3, r_s3p0;
    logic signed [NW-1:0]   r_n1, r_n2;

    assign k_s3 = {2'b00, i_s} + {1'b0, i_s, 1'b0};
    assign k_t3 = {2'b00, i_t} + {1'b0, i_t, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: first products
            r_t1   <= i_t;
            r_s1   <= i_s;
            r_p3t  <= i_p3 * $signed({1'b0, i_t});
            r_p0s  <= i_p0 * $signed({1'b0, i_s});
            r_e1k1 <= i_e1 * $signed({1'b0, k_s3});
            r_e2k1 <= i_e2 * $signed({1'b0, k_t3});
            r_b1   <= i_b;
            // stage 2
            r_t2   <= r_t1;
            r_s2   <= r_s1;
            r_p3tt <= r_p3t * $signed({1'b0, r_t1});
            r_p0ss <= r_p0s * $signed({1'b0, r_s1});
            r_e1k2 <= r_e1k1;
            r_e2k2 <= r_e2k1;
            r_b2   <= r_b1;
            // stage 3: cubes
            r_t3p3 <= r_p3tt * $signed({1'b0, r_t2});
            r_s3p0 <= r_p0ss * $signed({1'b0, r_s2});
            r_e1k3 <= r_e1k2;
            r_e2k3 <= r_e2k2;
            r_b3   <= r_b2;
            // stage 4: sums
            r_n1 <= (NW'(r_e1k3) <<< (2 * FB)) - (NW'(r_b3) <<< (3 * FB))
                  + NW'(r_t3p3) - (NW'(r_s3p0) <<< 1);
            r_n2 <= (NW'(r_e2k3) <<< (2 * FB)) - (NW'(r_b3) <<< (3 * FB))
                  - (NW'(r_t3p3) <<< 1) + NW'(r_s3p0);
        end
    end

    assign o_n1 = r_n1;
    assign o_n2 = r_n2;

endmodule

// ----- rtl/cfs_den.sv -----
// ----------------------------------------------------------------------------
// cfs_den: denominator pipeline
// d1 = 3ts^2 and d2 = 3t^2s, delayed to line up with the numerators.
// ----------------------------------------------------------------------------
module cfs_den #(
    parameter int FB = 16,
    parameter int DW = 3 * FB + 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [FB-1:0] i_t,
    input  logic [FB-1:0] i_s,
    output logic [DW-1:0] o_d1,
    output logic [DW-1:0] o_d2
);

    logic [FB+1:0]   k_t3;
    logic [2*FB+1:0] r_ts3;
    logic [FB-1:0]   r_t1, r_s1;
    logic [DW-1:0]   r_d1a, r_d2a, r_d1b, r_d2b, r_d1c, r_d2c;

    assign k_t3 = {2'b00, i_t} + {1'b0, i_t, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ts3 <= k_t3 * i_s;
            r_t1  <= i_t;
            r_s1  <= i_s;
            r_d1a <= r_ts3 * r_s1;
            r_d2a <= r_ts3 * r_t1;
            r_d1b <= r_d1a;
            r_d2b <= r_d2a;
            r_d1c <= r_d1b;
            r_d2c <= r_d2b;
        end
    end

    assign o_d1 = r_d1c;
    assign o_d2 = r_d2c;

endmodule

// ----- rtl/cfs_div.sv -----
// ----------------------------------------------------------------------------
// cfs_div: pipelined signed divider, one quotient bit per stage
// Rounds half away from zero and saturates to 32 bits.
// ----------------------------------------------------------------------------
module cfs_div #(
    parameter int NW = 84,
    parameter int DW = 50
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [NW-1:0]  i_num,
    input  logic [DW-1:0]         i_den,
    output cfs_pkg::t_div_res     o_res
);

    localparam int QB = cfs_pkg::QBITS;

    logic          r_neg_a;
    logic [NW-1:0] r_mag_a;
    logic [DW-1:0] r_den_a;

    logic [NW-1:0] r_rem [0:QB];
    logic [DW-1:0] r_dp  [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic          r_neg [0:QB];
    logic          r_ovf [0:QB];

    cfs_pkg::t_div_res r_res;

    logic [QB:0]   q_rnd;
    logic [QB:0]   lim;
    logic          rnd_up;
    logic          clip;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= i_num[NW-1];
            r_mag_a <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_den_a <= i_den;
            // quotient of 2^32 or more is out of range anyway
            r_ovf[0] <= r_mag_a >= NW'({r_den_a, QB'(0)});
            r_rem[0] <= r_mag_a;
            r_dp[0]  <= r_den_a;
            r_q[0]   <= '0;
            r_neg[0] <= r_neg_a;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_bit
        logic [NW-1:0] dsh;
        logic          ge;
        assign dsh = NW'(r_dp[k]) << (QB - 1 - k);
        assign ge  = r_rem[k] >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? r_rem[k] - dsh : r_rem[k];
                r_q[k+1]   <= {r_q[k][QB-2:0], ge};
                r_dp[k+1]  <= r_dp[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    always_comb begin
        rnd_up = {r_rem[QB], 1'b0} >= (NW+1)'(r_dp[QB]);
        q_rnd  = {1'b0, r_q[QB]} + (QB+1)'(rnd_up);
        lim    = r_neg[QB] ? (QB+1)'(1) << (QB - 1) : ((QB+1)'(1) << (QB - 1)) - 1'b1;
        clip   = r_ovf[QB] || (q_rnd > lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.clip <= clip;
            if (clip) begin
                r_res.value <= r_neg[QB] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r_res.value <= r_neg[QB] ? -q_rnd[QB-1:0] : q_rnd[QB-1:0];
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/cubic_from_struts.sv -----
// ----------------------------------------------------------------------------
// cubic_from_struts: cubic Bezier handles from an on-curve point and struts
// Pipelined ABC-construction handle rebuild with rounding and saturation.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  input   | i_in_valid  | o_in_stall  | i_in_data  (cfs_pkg::t_in_item)
//  output  | o_out_valid | i_out_stall | o_out_data (cfs_pkg::t_out_item)
//
// One transaction per cycle while the output is not stalled; the result passes
// through the input register, four product stages, 35 divider stages (sign,
// range, 32 quotient bits, rounding) and the output register.
// Reset clears only the valid line; no clearing pass.
// A stall on a valid output freezes the whole pipeline, the input stalls with it.
// ----------------------------------------------------------------------------
module cubic_from_struts #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cfs_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cfs_pkg::t_out_item   o_out_data
);

    localparam int FB   = FRACTION_BITS;
    localparam int NW   = 3 * FB + 36;
    localparam int DW   = 3 * FB + 2;
    localparam int TW   = (FB >= 16) ? FB + 1 : 17;
    localparam int SLAT = cfs_pkg::FRONT_LAT + cfs_pkg::DIV_LAT;
    localparam int VLAT = SLAT + 2;

    logic en;

    logic [VLAT-1:0]    r_vld;
    cfs_pkg::t_in_item  r_item;
    cfs_pkg::t_side     r_side [0:SLAT-1];
    cfs_pkg::t_out_item r_out;

    logic [TW-1:0] t_raw, t_clamp, t_one, s_full;
    logic [FB-1:0] t_eff, s_eff;
    cfs_pkg::t_side side_in;

    logic signed [NW-1:0] n1_x, n2_x, n1_y, n2_y;
    logic [DW-1:0]        d1, d2;
    cfs_pkg::t_div_res    q1_x, q1_y, q2_x, q2_y;

    assign en = !(r_vld[VLAT-1] && i_out_stall);

    always_comb begin
        t_one   = TW'(1) << FB;
        t_raw   = TW'(r_item.curve_position);
        t_clamp = (t_raw > t_one) ? t_one : t_raw;
        s_full  = t_one - t_clamp;
        t_eff   = t_clamp[FB-1:0];
        s_eff   = s_full[FB-1:0];
        side_in.bypass     = (t_clamp == '0) || (t_clamp == t_one);
        side_in.handle_one = r_item.first_handle;
        side_in.handle_two = r_item.second_handle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[VLAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item    <= i_in_data;
            r_side[0] <= side_in;
            for (int k = 1; k < SLAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    cfs_num #(.FB(FB), .NW(NW)) u_num_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (t_eff),
        .i_s   (s_eff),
        .i_p0  (r_item.start_point[63:32]),
        .i_p3  (r_item.end_point[63:32]),
        .i_b   (r_item.on_curve_point[63:32]),
        .i_e1  (r_item.strut_one[63:32]),
        .i_e2  (r_item.strut_two[63:32]),
        .o_n1  (n1_x),
        .o_n2  (n2_x)
    );

    cfs_num #(.FB(FB), .NW(NW)) u_num_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (t_eff),
        .i_s   (s_eff),
        .i_p0  (r_item.start_point[31:0]),
        .i_p3  (r_item.end_point[31:0]),
        .i_b   (r_item.on_curve_point[31:0]),
        .i_e1  (r_item.strut_one[31:0]),
        .i_e2  (r_item.strut_two[31:0]),
        .o_n1  (n1_y),
        .o_n2  (n2_y)
    );

    cfs_den #(.FB(FB), .DW(DW)) u_den (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (t_eff),
        .i_s   (s_eff),
        .o_d1  (d1),
        .o_d2  (d2)
    );

    cfs_div #(.NW(NW), .DW(DW)) u_div_1x (
        .i_clk (i_clk), .i_en (en), .i_num (n1_x), .i_den (d1), .o_res (q1_x)
    );
    cfs_div #(.NW(NW), .DW(DW)) u_div_1y (
        .i_clk (i_clk), .i_en (en), .i_num (n1_y), .i_den (d1), .o_res (q1_y)
    );
    cfs_div #(.NW(NW), .DW(DW)) u_div_2x (
        .i_clk (i_clk), .i_en (en), .i_num (n2_x), .i_den (d2), .o_res (q2_x)
    );
    cfs_div #(.NW(NW), .DW(DW)) u_div_2y (
        .i_clk (i_clk), .i_en (en), .i_num (n2_y), .i_den (d2), .o_res (q2_y)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_side[SLAT-1].bypass) begin
                r_out.new_handle_one_x <= r_side[SLAT-1].handle_one[63:32];
                r_out.new_handle_one_y <= r_side[SLAT-1].handle_one[31:0];
                r_out.new_handle_two_x <= r_side[SLAT-1].handle_two[63:32];
                r_out.new_handle_two_y <= r_side[SLAT-1].handle_two[31:0];
                r_out.clipped          <= 1'b0;
            end else begin
                r_out.new_handle_one_x <= q1_x.value;
                r_out.new_handle_one_y <= q1_y.value;
                r_out.new_handle_two_x <= q2_x.value;
                r_out.new_handle_two_y <= q2_y.value;
                r_out.clipped <= q1_x.clip || q1_y.clip || q2_x.clip || q2_y.clip;
            end
        end
    end

    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[VLAT-1];
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_stall_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall not tied to held output");

    a_bypass_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[VLAT-2] && r_side[SLAT-1].bypass) |=> !o_out_data.clipped)
        else $error("pass-through transaction flagged as clipped");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
